>>> hdl/gedge_pkg.sv
// Package for the gradient edge threshold block.
// Holds line geometry constants and derived widths; no dependencies.
package gedge_pkg;

	localparam int LINE_WIDTH = 1024;
	localparam int COL_W      = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
	localparam int FILL_W     = $clog2(LINE_WIDTH + 1);
	localparam int PIX_W      = 8;
	localparam logic [PIX_W-1:0] PIX_MAX = '1;

endpackage

>>> hdl/gedge_if.sv
// Valid/ready stream interfaces for pixel words in and edge words out.
// Uses gedge_pkg for the pixel width.
interface gedge_in_if;
	logic                          valid;
	logic                          ready;
	logic [gedge_pkg::PIX_W-1:0]   pixel;
	logic                          active;
	logic                          new_line;

	modport source (output valid, output pixel, output active, output new_line, input ready);
	modport sink   (input valid, input pixel, input active, input new_line, output ready);
endinterface

interface gedge_out_if;
	logic                          valid;
	logic                          ready;
	logic [gedge_pkg::PIX_W-1:0]   edge_res;
	logic                          active_out;

	modport source (output valid, output edge_res, output active_out, input ready);
	modport sink   (input valid, input edge_res, input active_out, output ready);
endinterface

>>> hdl/gedge_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module gedge_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/gradient_edge_threshold.sv
// 2x2 gradient edge detector, magnitude max(gh, gv, 3/4*(gh+gv)), thresholded, on a pixel stream.
// Path: an accepted word is registered into stage 1 with its RAM read, then into the result reg.
// Throughput: one word per cycle while the output is ready; output back-pressure stalls the pipe.
// Reset: arst_n clears column, fill count, running sums, threshold and valids.
// Line buffer needs no clearing pass: entries at or above the fill count read as zero.
module gradient_edge_threshold (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gedge_pkg::PIX_W-1:0]    cfg_data,
	gedge_in_if.sink                       in_ch,
	gedge_out_if.source                    out_ch
);

	localparam int COL_W  = gedge_pkg::COL_W;
	localparam int FILL_W = gedge_pkg::FILL_W;
	localparam int PIX_W  = gedge_pkg::PIX_W;

	logic [PIX_W-1:0]        thr_q;
	logic [COL_W-1:0]        col_q;
	logic [FILL_W-1:0]       fill_q;
	logic [PIX_W:0]          hsum_q;
	logic signed [PIX_W:0]   vdiff_q;

	logic                    valid_s1;
	logic [PIX_W-1:0]        pix_s1;
	logic                    act_s1;
	logic [COL_W-1:0]        addr_s1;
	logic                    fwd_s1;
	logic [PIX_W-1:0]        fwd_pix_s1;

	logic                    ovalid_q;
	logic [PIX_W-1:0]        edge_q;
	logic                    act_q;

	logic                    accept;
	logic                    advance;
	logic                    wr_en;
	logic [COL_W-1:0]        col_eff;
	logic [PIX_W-1:0]        rdata;

	logic [PIX_W-1:0]        top_pix;
	logic [PIX_W-1:0]        res;
	logic [PIX_W:0]          hsum_nxt;
	logic signed [PIX_W:0]   vdiff_nxt;

	assign advance      = valid_s1 && (!ovalid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign accept       = in_ch.valid && in_ch.ready;
	assign wr_en        = advance && act_s1;
	assign col_eff      = in_ch.new_line ? '0 : col_q;

	gedge_ram #(
		.WIDTH (PIX_W),
		.DEPTH (gedge_pkg::LINE_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (pix_s1),
		.re    (accept),
		.raddr (col_eff),
		.rdata (rdata)
	);

	// gradient and magnitude for the word in stage 1
	always_comb begin
		logic signed [PIX_W+2:0] hd;
		logic signed [PIX_W+2:0] vd;
		logic [PIX_W+1:0]        gh;
		logic [PIX_W+1:0]        gv;
		logic [PIX_W+2:0]        gsum;
		logic [PIX_W+4:0]        three;
		logic [PIX_W+2:0]        tq;
		logic [PIX_W+2:0]        mag;
		logic                    in_fill;
		logic signed [PIX_W+2:0] habs;
		logic signed [PIX_W+2:0] vabs;

		in_fill = {{(FILL_W-COL_W){1'b0}}, addr_s1} < fill_q;
		top_pix = in_fill ? (fwd_s1 ? fwd_pix_s1 : rdata) : '0;

		hd = $signed({2'b00, hsum_q}) - $signed({3'b000, top_pix})
			- $signed({3'b000, pix_s1});
		vd = $signed({{2{vdiff_q[PIX_W]}}, vdiff_q}) + $signed({3'b000, top_pix})
			- $signed({3'b000, pix_s1});
		habs = hd[PIX_W+2] ? -hd : hd;
		vabs = vd[PIX_W+2] ? -vd : vd;

		if (addr_s1 == '0) begin
			gh = '0;
			gv = '0;
		end else begin
			gh = habs[PIX_W+1:0];
			gv = vabs[PIX_W+1:0];
		end

		gsum  = {1'b0, gh} + {1'b0, gv};
		three = {1'b0, gsum, 1'b0} + {2'b00, gsum};
		tq    = three[PIX_W+4:2];

		mag = {1'b0, gh};
		if ({1'b0, gv} > mag) begin
			mag = {1'b0, gv};
		end
		if (tq > mag) begin
			mag = tq;
		end

		if (!act_s1) begin
			res = '0;
		end else if (mag > {3'b000, gedge_pkg::PIX_MAX}) begin
			res = gedge_pkg::PIX_MAX;
		end else if (mag[PIX_W-1:0] < thr_q) begin
			res = '0;
		end else begin
			res = mag[PIX_W-1:0];
		end

		hsum_nxt  = {1'b0, top_pix} + {1'b0, pix_s1};
		vdiff_nxt = $signed({1'b0, top_pix}) - $signed({1'b0, pix_s1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	// column pointer moves at accept; inactive words only honor new_line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (accept) begin
			if (!in_ch.active) begin
				col_q <= col_eff;
			end else if (col_eff == COL_W'(gedge_pkg::LINE_WIDTH - 1)) begin
				col_q <= '0;
			end else begin
				col_q <= col_eff + 1'b1;
			end
		end
	end

	// writes run from column 0 upward, so a count marks which entries are valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			hsum_q  <= '0;
			vdiff_q <= '0;
		end else if (wr_en) begin
			hsum_q  <= hsum_nxt;
			vdiff_q <= vdiff_nxt;
			if ({{(FILL_W-COL_W){1'b0}}, addr_s1} == fill_q) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// RAM read of the address being written this cycle returns stale data: forward
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= in_ch.pixel;
			act_s1     <= in_ch.active;
			addr_s1    <= col_eff;
			fwd_s1     <= wr_en && (col_eff == addr_s1);
			fwd_pix_s1 <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (advance) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			edge_q <= res;
			act_q  <= act_s1;
		end
	end

	assign out_ch.valid      = ovalid_q;
	assign out_ch.edge_res   = edge_q;
	assign out_ch.active_out = act_q;

endmodule

>>> hdl/gedge_chk.sv
// Port-level checker for gradient_edge_threshold, attached with bind.
// Depends on gedge_pkg for the pixel width.
module gedge_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [gedge_pkg::PIX_W-1:0] edge_res,
	input logic                        active_out
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// a stalled output word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(edge_res) && $stable(active_out))
		else $error("output word changed while stalled");

	// blanking words carry a zero edge value
	a_blank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active_out |-> edge_res == '0)
		else $error("inactive word with nonzero edge value");

	// every accepted word shows up at the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> ##2 out_valid)
		else $error("accepted word did not reach the output");

	// no output word without an earlier accepted input word
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_acc, 2))
		else $error("output word without matching input");

endmodule

bind gradient_edge_threshold gedge_chk u_gedge_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.edge_res   (out_ch.edge_res),
	.active_out (out_ch.active_out)
);

>>> bench/tb.sv
// Self-checking bench for gradient_edge_threshold: pixel stream in, edge words out.
// Depends on gedge_pkg, the gedge_in_if/gedge_out_if interfaces and the block itself.
module tb;

	localparam int PIX_W       = gedge_pkg::PIX_W;
	localparam int COL_W       = gedge_pkg::COL_W;
	localparam int LINE_WIDTH  = gedge_pkg::LINE_WIDTH;
	localparam logic [PIX_W-1:0] PIX_MAX = gedge_pkg::PIX_MAX;

	localparam int IDLE_PCT    = 22;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [PIX_W-1:0] edge_res;
		logic             active_out;
	} edge_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             act;
		logic             nl;
		logic             fixed;
		logic [PIX_W-1:0] exp_edge;
		logic             exp_act;
	} dir_row_t;

	localparam int DIR_ROWS = 18;
	// threshold is at its reset value of 0 for all of these rows
	localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
		'{8'h00, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1},	// column 0 right after reset
		'{8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h5A, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0},	// blanking
		'{8'hA5, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},	// new line during blanking
		'{8'hFF, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1},	// column 0 again
		'{8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},	// saturates
		'{8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h80, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1},
		'{8'h81, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h7F, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'h33, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0},	// blank mid-line
		'{8'h80, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'hFF, 1'b1, 1'b1, 1'b1, 8'h00, 1'b1},
		'{8'h00, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
		'{8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [PIX_W-1:0] cfg_data;

	gedge_in_if  in_ch ();
	gedge_out_if out_ch ();

	gradient_edge_threshold DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	// edge predictor state
	logic [PIX_W-1:0]   line_mem [0:LINE_WIDTH-1];
	logic [COL_W-1:0]   col_idx;
	logic [8:0]         hsum;
	logic signed [8:0]  vdiff;
	logic [PIX_W-1:0]   thr_reg;

	edge_word_t expected_q [$];
	int         mismatches;
	int         stall_cycles;
	bit         no_idle;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic edge_word_t predict_edge(input logic [PIX_W-1:0] pix,
			input logic act, input logic nl);
		edge_word_t         w;
		logic [PIX_W-1:0]   t;
		logic signed [10:0] dh, dv;
		logic [10:0]        gh, gv;
		logic [11:0]        three_q, mag;
		w = '0;
		w.active_out = act;
		if (nl)
			col_idx = '0;
		if (act) begin
			t = line_mem[col_idx];
			dh = $signed({2'b00, hsum}) - $signed({3'b000, t}) - $signed({3'b000, pix});
			dv = $signed({{2{vdiff[8]}}, vdiff}) + $signed({3'b000, t})
				- $signed({3'b000, pix});
			gh = (dh < 0) ? 11'(-dh) : 11'(dh);
			gv = (dv < 0) ? 11'(-dv) : 11'(dv);
			if (col_idx == '0) begin
				gh = '0;
				gv = '0;
			end
			hsum  = {1'b0, t} + {1'b0, pix};
			vdiff = {1'b0, t} - {1'b0, pix};
			line_mem[col_idx] = pix;
			three_q = 12'(((12'(gh) + 12'(gv)) * 3) >> 2);
			mag = 12'(gh);
			if (12'(gv) > mag)
				mag = 12'(gv);
			if (three_q > mag)
				mag = three_q;
			if (mag > 12'd255)
				w.edge_res = PIX_MAX;
			else if (mag[7:0] < thr_reg)
				w.edge_res = '0;
			else
				w.edge_res = mag[7:0];
			if (col_idx == COL_W'(LINE_WIDTH - 1))
				col_idx = '0;
			else
				col_idx = col_idx + 1'b1;
		end
		return w;
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		logic [PIX_W-1:0] p;
		case ($urandom_range(0, 3))
			0: p = $urandom_range(0, 1) ? PIX_MAX : '0;
			1: p = PIX_W'(120 + $urandom_range(0, 16));	// low-contrast area
			default: p = PIX_W'($urandom);
		endcase
		return p;
	endfunction

	task automatic send_word(input logic [PIX_W-1:0] pix, input logic act, input logic nl,
			input logic fixed, input edge_word_t fixed_word);
		edge_word_t pw;
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.pixel    <= pix;
		in_ch.active   <= act;
		in_ch.new_line <= nl;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pw = predict_edge(pix, act, nl);
		expected_q.push_back(fixed ? fixed_word : pw);
	endtask

	// wait until every expected word is out and the pipe is empty
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [PIX_W-1:0] v);
		cfg_data <= v;
		cfg_we   <= 1'b1;
		@(posedge clk);
		thr_reg = v;
		cfg_we <= 1'b0;
	endtask

	// lines of random length separated by blanking, with some stray flags
	task automatic send_lines(input int n_items, input int max_len);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			repeat ($urandom_range(0, 3)) begin
				send_word(pick_pixel(), 1'b0, $urandom_range(0, 7) == 0, 1'b0, '0);
				sent++;
			end
			len = $urandom_range(1, max_len);
			for (int i = 0; i < len; i++) begin
				send_word(pick_pixel(), $urandom_range(0, 29) != 0,
					(i == 0) || ($urandom_range(0, 49) == 0), 1'b0, '0);
				sent++;
			end
		end
	endtask

	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			stall_cycles <= 0;
		else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	always @(posedge clk) begin
		edge_word_t got;
		edge_word_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.edge_res   = out_ch.edge_res;
			got.active_out = out_ch.active_out;
			if (expected_q.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected word: edge_res=%0d active_out=%0b",
						got.edge_res, got.active_out);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				if (got.edge_res !== want.edge_res || got.active_out !== want.active_out) begin
					if (mismatches < MAX_REPORTS)
						$display("word mismatch: edge_res exp %0d got %0d, active_out exp %0b got %0b",
							want.edge_res, got.edge_res, want.active_out, got.active_out);
					mismatches++;
				end
			end
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("gradient_edge_threshold: mismatch");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_data       = '0;
		in_ch.valid    = 1'b0;
		in_ch.pixel    = '0;
		in_ch.active   = 1'b0;
		in_ch.new_line = 1'b0;
		no_idle        = 1'b0;
		for (int i = 0; i < LINE_WIDTH; i++)
			line_mem[i] = '0;
		col_idx = '0;
		hsum    = '0;
		vdiff   = '0;
		thr_reg = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_word(DIR_TAB[i].pix, DIR_TAB[i].act, DIR_TAB[i].nl, DIR_TAB[i].fixed,
				'{DIR_TAB[i].exp_edge, DIR_TAB[i].exp_act});

		drain();
		set_threshold(PIX_MAX);
		send_lines(50, 40);

		drain();
		set_threshold(8'd1);
		no_idle = 1'b1;
		send_lines(50, 40);
		drain();
		no_idle = 1'b0;

		set_threshold(PIX_W'($urandom_range(2, 40)));
		send_lines(50, 40);

		drain();
		set_threshold('0);
		send_lines(50, 40);

		drain();
		set_threshold(8'd128);
		send_lines(50, 40);

		drain();
		set_threshold(PIX_W'($urandom_range(0, 255)));
		send_lines(20, 40);

		drain();
		if (mismatches == 0 && expected_q.size() == 0)
			$display("gradient_edge_threshold: match");
		else
			$display("gradient_edge_threshold: mismatch");
		$finish;
	end

endmodule
